// ===== src/sda_pkg.sv =====
`default_nettype none
package sda_pkg;

  // Level limits and constants, 1/256 dB
  localparam int LVL_FLOOR = -51200;
  localparam int LVL_TOP   = 51199;
  localparam logic signed [16:0] LVL_FLOOR_V = -17'sd51200;
  localparam logic signed [16:0] LVL_TOP_V   = 17'sd51199;
  localparam logic signed [16:0] LVL_RESET_V = -17'sd25600;
  localparam logic signed [16:0] LVL_ZERO_V  = 17'sd0;
  localparam logic signed [16:0] DB_OFFSET_RST = -17'sd16947;

  // 10*log10(2) * 256 in Q16 (log2 in Q16, product in Q32)
  localparam logic [25:0] LOG_TO_DB = 26'd50504453;
  localparam logic signed [14:0] ALPHA_Q16 = 15'sd6554;
  localparam logic [47:0] LOG_RND = 48'h0000_8000_0000;
  localparam logic signed [31:0] BLEND_RND = 32'sd32768;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SQRE, S_SQIM, S_START, S_LOG,
    S_SCALE, S_LEVEL, S_BLEND, S_FINAL
  } core_state_e;

  typedef enum logic [1:0] {
    L_IDLE, L_NORM, L_SQR
  } log_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } log_stat_t;

  // saturate to the level range
  function automatic logic signed [16:0] clamp_lvl(input logic signed [19:0] v);
    logic signed [16:0] r;
    if (v < LVL_FLOOR) r = LVL_FLOOR_V;
    else if (v > LVL_TOP) r = LVL_TOP_V;
    else r = v[16:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/sda_if.sv =====
`default_nettype none
// Bin beat channel
interface sda_bin_if #(parameter int BIN_WIDTH = 24);
  logic                        valid;
  logic                        ready;
  logic [11:0]                 bin_index;
  logic signed [BIN_WIDTH-1:0] bin_re;
  logic signed [BIN_WIDTH-1:0] bin_im;
  logic                        frame_first;
  logic                        frame_last;
  modport source (output valid, bin_index, bin_re, bin_im, frame_first, frame_last,
                  input ready);
  modport sink (input valid, bin_index, bin_re, bin_im, frame_first, frame_last,
                output ready);
endinterface

// Result beat channel
interface sda_res_if;
  logic               valid;
  logic               ready;
  logic [11:0]        out_index;
  logic signed [16:0] level_db;
  logic signed [16:0] frame_min_db;
  logic signed [16:0] frame_max_db;
  logic               frame_done;
  modport source (output valid, out_index, level_db, frame_min_db, frame_max_db,
                  frame_done, input ready);
  modport sink (input valid, out_index, level_db, frame_min_db, frame_max_db,
                frame_done, output ready);
endinterface
`default_nettype wire

// ===== src/spectrum_db_averager_core.sv =====
`default_nettype none
// Channel   Dir  Beat
// bin_i     in   bin_index, bin_re, bin_im, frame_first, frame_last
// res_o     out  out_index, level_db, frame_min_db, frame_max_db, frame_done
// db_offset in   write enable + 17-bit value, no read-back
//
// One bin at a time; each bin is paced by the 16 squaring steps of the log2
// unit plus its leading-one search (8 or 1 bit per cycle), skipped with zero
// power, and for SPECTRUM_LEN below 4096 by the index reduction (one subtract
// per cycle). After reset the level store is cleared with bin_i.ready low. A
// result waiting in the output register does not block the next bin; only the
// final write-back waits.
module spectrum_db_averager_core #(
  parameter int SPECTRUM_LEN = 4096,
  parameter int BIN_WIDTH    = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               db_offset_we_i,
  input  wire logic signed [16:0] db_offset_i,
  sda_bin_if.sink                 bin_i,
  sda_res_if.source               res_o
);
  localparam int PW = 2 * BIN_WIDTH;
  localparam int NW = (PW < 32) ? 32 : PW;
  localparam int LGW = $clog2(NW) + 16;
  localparam int AW = $clog2(SPECTRUM_LEN);
  localparam int IW = ((AW > 12) ? AW : 12) + 1;
  localparam logic [IW-1:0] LEN_V  = IW'(SPECTRUM_LEN);
  localparam logic [IW-1:0] HALF_V = IW'(SPECTRUM_LEN / 2);
  localparam logic [AW-1:0] LAST_A = AW'(SPECTRUM_LEN - 1);

  sda_pkg::core_state_e state_q, state_d;
  logic signed [16:0] db_off_q;
  logic [AW-1:0] clr_q;
  logic [IW-1:0] idx_q, pos_q, pos_sum;
  logic signed [BIN_WIDTH-1:0] re_q, im_q;
  logic [BIN_WIDTH-1:0] are, aim, mop;
  logic [PW-1:0] sqm, acc_q;
  logic first_q, last_q, zero_q;
  logic [47:0] prod_q, prod_rnd;
  logic signed [16:0] lvl_q, old_q, sm;
  logic signed [19:0] lvl_sum, sm_sum;
  logic signed [17:0] diff;
  logic signed [31:0] dmul_q, blend_t;
  logic signed [16:0] run_min_q, run_max_q, base_min, base_max;
  logic signed [16:0] rdata;
  logic idx_ok, out_free, log_start;
  sda_pkg::log_stat_t log_stat;
  logic [LGW-1:0] log_val;

  // log2 unit
  sda_log2 #(.PW(PW)) u_log2 (
    .clk_i, .rst_ni, .start_i(log_start), .p_i(acc_q),
    .stat_o(log_stat), .log_o(log_val)
  );

  // level store: clear pass writes the reset level, final step writes back
  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic signed [16:0] mem_wdata;
  assign mem_we    = (state_q == sda_pkg::S_CLEAR) || (state_q == sda_pkg::S_FINAL && out_free);
  assign mem_waddr = (state_q == sda_pkg::S_CLEAR) ? clr_q : pos_q[AW-1:0];
  assign mem_wdata = (state_q == sda_pkg::S_CLEAR) ? sda_pkg::LVL_RESET_V : sm;

  sda_level_mem #(.DEPTH(SPECTRUM_LEN), .AW(AW)) u_mem (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .re_i(state_q == sda_pkg::S_LEVEL), .raddr_i(pos_q[AW-1:0]), .rdata_o(rdata)
  );

  // magnitudes and shared squarer
  assign are = re_q[BIN_WIDTH-1] ? BIN_WIDTH'(-re_q) : BIN_WIDTH'(re_q);
  assign aim = im_q[BIN_WIDTH-1] ? BIN_WIDTH'(-im_q) : BIN_WIDTH'(im_q);
  assign mop = (state_q == sda_pkg::S_SQRE) ? are : aim;
  assign sqm = PW'(mop) * PW'(mop);

  assign idx_ok    = (idx_q < LEN_V);
  assign pos_sum   = idx_q + HALF_V;
  assign log_start = (state_q == sda_pkg::S_START) && (acc_q != '0);
  assign out_free  = !res_o.valid || res_o.ready;

  // level: raw dB from log2, plus offset, saturated
  assign prod_rnd = prod_q + sda_pkg::LOG_RND;
  assign lvl_sum  = $signed({4'b0, prod_rnd[47:32]}) + $signed({{3{db_off_q[16]}}, db_off_q});

  // smoothing and running extremes
  assign diff     = {lvl_q[16], lvl_q} - {rdata[16], rdata};
  assign blend_t  = dmul_q + sda_pkg::BLEND_RND;
  assign sm_sum   = $signed({{3{old_q[16]}}, old_q}) + $signed({{4{blend_t[31]}}, blend_t[31:16]});
  assign sm       = sda_pkg::clamp_lvl(sm_sum);
  assign base_min = first_q ? sda_pkg::LVL_ZERO_V : run_min_q;
  assign base_max = first_q ? sda_pkg::LVL_FLOOR_V : run_max_q;

  // state register and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sda_pkg::S_CLEAR;
      clr_q       <= '0;
      db_off_q    <= sda_pkg::DB_OFFSET_RST;
      run_min_q   <= sda_pkg::LVL_ZERO_V;
      run_max_q   <= sda_pkg::LVL_FLOOR_V;
      res_o.valid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (db_offset_we_i) db_off_q <= db_offset_i;
      if (state_q == sda_pkg::S_CLEAR) clr_q <= clr_q + AW'(1);
      if (state_q == sda_pkg::S_FINAL && out_free) begin
        res_o.valid <= 1'b1;
        run_min_q   <= (sm < base_min) ? sm : base_min;
        run_max_q   <= (sm > base_max) ? sm : base_max;
      end else if (res_o.ready) begin
        res_o.valid <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sda_pkg::S_CLEAR: if (clr_q == LAST_A) state_d = sda_pkg::S_IDLE;
      sda_pkg::S_IDLE:  if (bin_i.valid) state_d = sda_pkg::S_SQRE;
      sda_pkg::S_SQRE:  state_d = sda_pkg::S_SQIM;
      sda_pkg::S_SQIM:  state_d = sda_pkg::S_START;
      sda_pkg::S_START: state_d = sda_pkg::S_LOG;
      sda_pkg::S_LOG: begin
        if (idx_ok && (zero_q || log_stat.done)) state_d = sda_pkg::S_SCALE;
      end
      sda_pkg::S_SCALE: state_d = sda_pkg::S_LEVEL;
      sda_pkg::S_LEVEL: state_d = sda_pkg::S_BLEND;
      sda_pkg::S_BLEND: state_d = sda_pkg::S_FINAL;
      sda_pkg::S_FINAL: if (out_free) state_d = sda_pkg::S_IDLE;
      default:          state_d = sda_pkg::S_IDLE;
    endcase
  end

  assign bin_i.ready = (state_q == sda_pkg::S_IDLE);

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == sda_pkg::S_IDLE && bin_i.valid) begin
      idx_q   <= IW'(bin_i.bin_index);
      re_q    <= bin_i.bin_re;
      im_q    <= bin_i.bin_im;
      first_q <= bin_i.frame_first;
      last_q  <= bin_i.frame_last;
    end else if (!idx_ok) begin
      idx_q <= idx_q - LEN_V;
    end
    if (state_q == sda_pkg::S_SQRE) acc_q <= sqm;
    if (state_q == sda_pkg::S_SQIM) acc_q <= acc_q + sqm;
    if (state_q == sda_pkg::S_START) zero_q <= (acc_q == '0);
    if (state_q == sda_pkg::S_SCALE) begin
      prod_q <= 48'(log_val) * 48'(sda_pkg::LOG_TO_DB);
      pos_q  <= (pos_sum >= LEN_V) ? (pos_sum - LEN_V) : pos_sum;
    end
    if (state_q == sda_pkg::S_LEVEL) begin
      lvl_q <= zero_q ? sda_pkg::LVL_FLOOR_V : sda_pkg::clamp_lvl(lvl_sum);
    end
    if (state_q == sda_pkg::S_BLEND) begin
      old_q  <= rdata;
      dmul_q <= diff * sda_pkg::ALPHA_Q16;
    end
    if (state_q == sda_pkg::S_FINAL && out_free) begin
      res_o.out_index    <= pos_q[11:0];
      res_o.level_db     <= sm;
      res_o.frame_min_db <= (sm < base_min) ? sm : base_min;
      res_o.frame_max_db <= (sm > base_max) ? sm : base_max;
      res_o.frame_done   <= last_q;
    end
  end
endmodule
`default_nettype wire

// ===== src/sda_log2.sv =====
`default_nettype none
// log2 in Q16: leading-one search, then one squaring per cycle for the fraction
module sda_log2 #(
  parameter int PW = 48
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start_i,
  input  wire logic [PW-1:0]                          p_i,
  output sda_pkg::log_stat_t                          stat_o,
  output logic [$clog2((PW < 32) ? 32 : PW)+15:0]     log_o
);
  localparam int NW = (PW < 32) ? 32 : PW;
  localparam int LW = $clog2(NW);

  sda_pkg::log_state_e state_q, state_d;
  logic [NW-1:0] norm_q;
  logic [LW-1:0] n_q;
  logic [31:0]   m_q;
  logic [15:0]   frac_q;
  logic [3:0]    cnt_q;
  logic          done_q;
  logic [63:0]   sq;

  assign sq = 64'(m_q) * 64'(m_q);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sda_pkg::L_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start_i) done_q <= 1'b0;
      else if (state_q == sda_pkg::L_SQR && cnt_q == 4'hF) done_q <= 1'b1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sda_pkg::L_IDLE: if (start_i) state_d = sda_pkg::L_NORM;
      sda_pkg::L_NORM: if (norm_q[NW-1]) state_d = sda_pkg::L_SQR;
      sda_pkg::L_SQR:  if (cnt_q == 4'hF) state_d = sda_pkg::L_IDLE;
      default:         state_d = sda_pkg::L_IDLE;
    endcase
  end

  // datapath; the result holds in idle until the next start
  always_ff @(posedge clk_i) begin
    case (state_q)
      sda_pkg::L_IDLE: begin
        if (start_i) begin
          norm_q <= NW'(p_i);
          n_q    <= LW'(NW - 1);
          cnt_q  <= 4'd0;
          frac_q <= 16'd0;
        end
      end
      sda_pkg::L_NORM: begin
        // coarse step of 8 when the top byte is empty
        if (norm_q[NW-1]) begin
          m_q <= norm_q[NW-1 -: 32];
        end else if (norm_q[NW-1 -: 8] == 8'd0) begin
          norm_q <= norm_q << 8;
          n_q    <= n_q - LW'(8);
        end else begin
          norm_q <= norm_q << 1;
          n_q    <= n_q - LW'(1);
        end
      end
      sda_pkg::L_SQR: begin
        cnt_q <= cnt_q + 4'd1;
        if (sq[63]) begin
          m_q    <= sq[63:32];
          frac_q <= {frac_q[14:0], 1'b1};
        end else begin
          m_q    <= sq[62:31];
          frac_q <= {frac_q[14:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign log_o  = {n_q, frac_q};
  assign stat_o = '{busy: (state_q != sda_pkg::L_IDLE), done: done_q};
endmodule
`default_nettype wire

// ===== src/sda_level_mem.sv =====
`default_nettype none
// Per-bin smoothed level store, one write and one registered read port
module sda_level_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [AW-1:0]         waddr_i,
  input  wire logic signed [16:0]    wdata_i,
  input  wire logic                  re_i,
  input  wire logic [AW-1:0]         raddr_i,
  output logic signed [16:0]         rdata_o
);
  logic signed [16:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== src/sda_checker.sv =====
`default_nettype none
// Port-level checks of the averager
module sda_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic signed [16:0] level_i,
  input wire logic signed [16:0] min_i,
  input wire logic signed [16:0] max_i
);
  // a stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(level_i) && $stable(min_i)
      && $stable(max_i))
    else $error("result beat changed while stalled");

  // the frame extremes bracket the bin level
  a_bracket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (min_i <= level_i) && (level_i <= max_i))
    else $error("level outside frame min/max");

  // minimum never rises above 0 dB and level stays in range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (min_i <= 17'sd0) && (level_i >= sda_pkg::LVL_FLOOR_V)
      && (level_i <= sda_pkg::LVL_TOP_V))
    else $error("level out of range");

  // one bin in flight: no accept right after an accept
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("bin accepted while busy");
endmodule

bind spectrum_db_averager_core sda_checker u_sda_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (bin_i.valid),
  .in_ready_i  (bin_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .level_i     (res_o.level_db),
  .min_i       (res_o.frame_min_db),
  .max_i       (res_o.frame_max_db)
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam int BINS       = 4096;
  localparam int CYCLE_CAP  = 2000000;
  localparam int DRAIN_CYC  = 60;
  localparam logic signed [23:0] RE_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] RE_MIN = -24'sh800000;

  typedef struct {
    logic [11:0]        idx;
    logic signed [16:0] lvl;
    logic signed [16:0] lo;
    logic signed [16:0] hi;
    logic               done;
  } level_beat_t;

  typedef struct {
    logic [11:0]        idx;
    logic signed [23:0] re;
    logic signed [23:0] im;
    logic               first;
    logic               last;
    bit                 typed;
    logic signed [16:0] typed_lvl;
  } bin_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic db_offset_we_i = 1'b0;
  logic signed [16:0] db_offset_i = '0;

  sda_bin_if #(.BIN_WIDTH(24)) bin_if ();
  sda_res_if res_if ();

  spectrum_db_averager_core #(.SPECTRUM_LEN(BINS), .BIN_WIDTH(24)) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .db_offset_we_i (db_offset_we_i),
    .db_offset_i    (db_offset_i),
    .bin_i          (bin_if),
    .res_o          (res_if)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mirror state of the averager
  logic signed [16:0] avg_store [BINS];
  logic signed [16:0] run_lo, run_hi, offset_mirror;
  level_beat_t        pending_levels[$];
  bit                 typed_pending[$];
  logic signed [16:0] typed_values[$];
  int                 fail_cnt = 0;
  int                 gap_pct = 0, stall_pct = 0, holdoff = 0;
  longint             cycle_cnt = 0;

  function automatic logic signed [16:0] sat_level(longint v);
    if (v < sda_pkg::LVL_FLOOR) return sda_pkg::LVL_FLOOR_V;
    if (v > sda_pkg::LVL_TOP) return sda_pkg::LVL_TOP_V;
    return v[16:0];
  endfunction

  // log2 in Q16 by leading-one search and repeated squaring
  function automatic longint unsigned log2_fix(longint unsigned p);
    int unsigned lead;
    longint unsigned mant, frac;
    lead = 0;
    frac = 0;
    for (int k = 0; k < 64; k++) if (p[k]) lead = k;
    mant = (lead >= 31) ? (p >> (lead - 31)) : (p << (31 - lead));
    for (int k = 0; k < 16; k++) begin
      mant = (mant * mant) >> 31;
      frac = frac << 1;
      if (mant >= 64'h1_0000_0000) begin
        mant = mant >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(lead) << 16) | frac;
  endfunction

  // dB level, blend into the store, update the frame extremes
  function automatic level_beat_t average_bin(logic [11:0] idx, logic signed [23:0] re,
                                              logic signed [23:0] im, logic first,
                                              logic last);
    level_beat_t r;
    longint are, aim, d, t;
    longint unsigned pwr, raw;
    logic [11:0] pos;
    logic signed [16:0] lvl, old, sm;
    are = (re < 0) ? -longint'(re) : longint'(re);
    aim = (im < 0) ? -longint'(im) : longint'(im);
    pwr = are * are + aim * aim;
    pos = idx + 12'd2048;
    if (pwr == 0) lvl = sda_pkg::LVL_FLOOR_V;
    else begin
      raw = (log2_fix(pwr) * 64'd50504453 + 64'h8000_0000) >> 32;
      lvl = sat_level(longint'(raw) + longint'(offset_mirror));
    end
    old = avg_store[pos];
    d = longint'(lvl) - longint'(old);
    t = d * 6554 + 32768;
    sm = sat_level(longint'(old) + (t >>> 16));
    avg_store[pos] = sm;
    if (first) begin
      run_lo = sda_pkg::LVL_ZERO_V;
      run_hi = sda_pkg::LVL_FLOOR_V;
    end
    if (sm > run_hi) run_hi = sm;
    if (sm < run_lo) run_lo = sm;
    r.idx = pos;
    r.lvl = sm;
    r.lo = run_lo;
    r.hi = run_hi;
    r.done = last;
    return r;
  endfunction

  task automatic check_field(string name, longint expv, longint actv);
    if (expv != actv) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
      fail_cnt++;
    end
  endtask

  // accepted beats: predict on bin side, compare on result side
  always @(posedge clk_i) begin
    level_beat_t e;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && bin_if.valid && bin_if.ready) begin
      e = average_bin(bin_if.bin_index, bin_if.bin_re, bin_if.bin_im,
                      bin_if.frame_first, bin_if.frame_last);
      if (typed_pending.size() > 0 && typed_pending.pop_front()) e.lvl = typed_values.pop_front();
      pending_levels.push_back(e);
    end
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected result beat, index %0d", $time, res_if.out_index);
        fail_cnt++;
      end else begin
        e = pending_levels.pop_front();
        check_field("out_index", e.idx, res_if.out_index);
        check_field("level_db", e.lvl, res_if.level_db);
        check_field("frame_min_db", e.lo, res_if.frame_min_db);
        check_field("frame_max_db", e.hi, res_if.frame_max_db);
        check_field("frame_done", e.done, res_if.frame_done);
      end
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(negedge clk_i) begin
    if (holdoff > 0) begin
      res_if.ready <= 1'b0;
      holdoff <= holdoff - 1;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    if (cycle_cnt > CYCLE_CAP) begin
      $display("** spectrum_db_averager_core: FAILED **");
      $finish;
    end
  end

  // offer one bin beat, with random gaps before it
  task automatic send_bin(bin_row_t row);
    while ($urandom_range(0, 99) < gap_pct) begin
      bin_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    typed_pending.push_back(row.typed);
    if (row.typed) typed_values.push_back(row.typed_lvl);
    bin_if.valid       <= 1'b1;
    bin_if.bin_index   <= row.idx;
    bin_if.bin_re      <= row.re;
    bin_if.bin_im      <= row.im;
    bin_if.frame_first <= row.first;
    bin_if.frame_last  <= row.last;
    do @(posedge clk_i); while (!bin_if.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    bin_if.valid <= 1'b0;
    while (pending_levels.size() > 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
  endtask

  task automatic write_offset(logic signed [16:0] v);
    db_offset_we_i <= 1'b1;
    db_offset_i    <= v;
    offset_mirror = v;
    @(negedge clk_i);
    db_offset_we_i <= 1'b0;
  endtask

  // component with a random magnitude scale
  function automatic logic signed [23:0] rand_part();
    logic signed [23:0] v;
    v = 24'($urandom);
    if ($urandom_range(0, 15) == 0) return '0;
    return v >>> $urandom_range(0, 23);
  endfunction

  bin_row_t directed_rows[] = '{
    '{12'd0,    24'sd0,  24'sd0,  1'b1, 1'b0, 1'b1, -17'sd28160},
    '{12'd4095, RE_MAX,  RE_MAX,  1'b0, 1'b0, 1'b0, '0},
    '{12'd2047, RE_MIN,  RE_MIN,  1'b0, 1'b0, 1'b0, '0},
    '{12'd2048, 24'sd1,  24'sd0,  1'b0, 1'b0, 1'b0, '0},
    '{12'd1,    -24'sd1, -24'sd1, 1'b0, 1'b1, 1'b0, '0},
    '{12'd100,  24'sd0,  RE_MAX,  1'b1, 1'b0, 1'b0, '0},
    '{12'd100,  24'sd0,  RE_MAX,  1'b0, 1'b0, 1'b0, '0},
    '{12'd100,  RE_MIN,  24'sd0,  1'b0, 1'b0, 1'b0, '0},
    '{12'd2730, 24'sd3,  -24'sd4, 1'b1, 1'b1, 1'b0, '0},
    '{12'd1365, 24'sd0,  24'sd0,  1'b0, 1'b0, 1'b0, '0}
  };

  initial begin
    bin_row_t row;
    logic signed [16:0] offsets[4];
    logic [11:0] base;
    int flen, sent;
    int ph_gap, ph_stall;
    for (int i = 0; i < BINS; i++) avg_store[i] = sda_pkg::LVL_RESET_V;
    run_lo = sda_pkg::LVL_ZERO_V;
    run_hi = sda_pkg::LVL_FLOOR_V;
    offset_mirror = sda_pkg::DB_OFFSET_RST;
    bin_if.valid = 1'b0;
    bin_if.bin_index = '0;
    bin_if.bin_re = '0;
    bin_if.bin_im = '0;
    bin_if.frame_first = 1'b0;
    bin_if.frame_last = 1'b0;
    res_if.ready = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, reset offset
    foreach (directed_rows[i]) send_bin(directed_rows[i]);
    wait_idle();

    // saturation at the offset extremes
    offsets = '{-17'sd65536, 17'sd65535, 17'sd0, sda_pkg::DB_OFFSET_RST};
    for (int k = 0; k < 2; k++) begin
      write_offset(offsets[k]);
      foreach (directed_rows[i]) begin
        row = directed_rows[i];
        row.typed = 1'b0;
        send_bin(row);
      end
      wait_idle();
    end

    // random part: four phases with different gap and stall rates, each with its own offset
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin ph_gap = 0;  ph_stall = 0;  end
        1: begin ph_gap = 50; ph_stall = 0;  end
        2: begin ph_gap = 0;  ph_stall = 50; end
        default: begin ph_gap = 32; ph_stall = 32; end
      endcase
      gap_pct = ph_gap;
      stall_pct = ph_stall;
      write_offset(ph == 2 ? 17'($urandom) : offsets[ph]);
      if (ph == 1) holdoff = 400;
      sent = 0;
      while (sent < 400) begin
        // now and then a stretch with no idling
        if ($urandom_range(0, 9) == 0) begin
          gap_pct = 0;
          stall_pct = 0;
        end else begin
          gap_pct = ph_gap;
          stall_pct = ph_stall;
        end
        if ($urandom_range(0, 4) != 0) begin
          // well-formed frame of consecutive bins
          flen = $urandom_range(1, 40);
          base = 12'($urandom);
          for (int j = 0; j < flen; j++) begin
            row.idx = base + j[11:0];
            row.re = rand_part();
            row.im = rand_part();
            row.first = (j == 0);
            row.last = (j == flen - 1);
            row.typed = 1'b0;
            send_bin(row);
          end
          sent += flen;
        end else begin
          // stray bin with random flags
          row.idx = 12'($urandom);
          row.re = 24'($urandom);
          row.im = 24'($urandom);
          row.first = 1'($urandom);
          row.last = 1'($urandom);
          row.typed = 1'b0;
          send_bin(row);
          sent++;
        end
      end
      wait_idle();
    end

    if (fail_cnt == 0) $display("** spectrum_db_averager_core: PASSED **");
    else $display("** spectrum_db_averager_core: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
